// File: rtl/ldsw_pkg.sv
// Shared constants, request codes and the request record of the LED display serial writer.
package ldsw_pkg;

  localparam int DIGITS        = 4;
  localparam int BITS_PER_BYTE = 8;
  localparam int STORE_DEPTH   = 4;
  localparam int STORE_IDX_W   = $clog2(STORE_DEPTH);
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
  localparam int IDX_W         = 3;
  localparam int BYTE_W        = 8;
  localparam int LEVEL_W       = 3;
  localparam int BRIGHT_W      = 4;
  localparam int MODE_W        = 2;
  localparam int PACKET_W      = 2;

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHOW  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [BRIGHT_W-1:0] MAX_LEVEL = 4'd7;

  localparam logic [BYTE_W-1:0] CMD_DATA_SET = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_ADDRESS  = 8'hC0;
  localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h88;
  localparam logic [BYTE_W-1:0] CMD_DISP_OFF = 8'h80;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_TICK  = 2'd0;
  localparam kind_t KIND_SHOW  = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;
  localparam kind_t KIND_BAD   = 2'd3;

  typedef struct packed {
    kind_t                                 kind;
    logic [STORE_DEPTH-1:0][BYTE_W-1:0]    digits;
    logic [LEVEL_W-1:0]                    level;
    logic                                  pin;
  } req_t;

endpackage

// File: rtl/ldsw_front.sv
// Front end: classifies each incoming request as a tick, a show, a clear or a refused show.
module ldsw_front (
  input  logic [ldsw_pkg::MODE_W-1:0]   mode,
  input  logic [ldsw_pkg::BYTE_W-1:0]   digit0,
  input  logic [ldsw_pkg::BYTE_W-1:0]   digit1,
  input  logic [ldsw_pkg::BYTE_W-1:0]   digit2,
  input  logic [ldsw_pkg::BYTE_W-1:0]   digit3,
  input  logic [ldsw_pkg::BRIGHT_W-1:0] brightness,
  input  logic                          data_pin_in,
  output ldsw_pkg::req_t                req
);

  always_comb begin
    req.digits = {digit3, digit2, digit1, digit0};
    req.level  = brightness[ldsw_pkg::LEVEL_W-1:0];
    req.pin    = data_pin_in;
    unique case (mode)
      ldsw_pkg::MODE_SHOW: begin
        req.kind = (brightness > ldsw_pkg::MAX_LEVEL) ? ldsw_pkg::KIND_BAD : ldsw_pkg::KIND_SHOW;
      end
      ldsw_pkg::MODE_CLEAR: begin
        req.kind = ldsw_pkg::KIND_CLEAR;
      end
      default: begin
        req.kind = ldsw_pkg::KIND_TICK;
      end
    endcase
  end

endmodule

// File: rtl/ldsw_queue.sv
// Two-entry queue that carries classified requests from the front end to the sequencer.
module ldsw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  ldsw_pkg::req_t push_req,
  output logic           push_stall,
  output logic           pop_valid,
  output ldsw_pkg::req_t pop_req,
  input  logic           pop_ready
);

  ldsw_pkg::req_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  logic           pop;

  assign push_stall = (count_r == 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_req    = entry_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/ldsw_back.sv
// Back end: the line sequencer, the latched segment bytes and the result register.
module ldsw_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  input  ldsw_pkg::req_t req,
  output logic           req_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_clock_level,
  output logic           out_data_level,
  output logic           out_data_drive,
  output logic           out_busy_res,
  output logic           out_frame_done,
  output logic           out_rejected
);

  localparam logic [3:0] P_IDLE     = 4'd0;
  localparam logic [3:0] P_START    = 4'd1;
  localparam logic [3:0] P_BIT_LOW  = 4'd2;
  localparam logic [3:0] P_BIT_HIGH = 4'd3;
  localparam logic [3:0] P_ACK_REL  = 4'd4;
  localparam logic [3:0] P_ACK_WAIT = 4'd5;
  localparam logic [3:0] P_STOP_LOW = 4'd6;
  localparam logic [3:0] P_STOP_CLK = 4'd7;
  localparam logic [3:0] P_STOP_DAT = 4'd8;

  logic [3:0]                         phase_r, phase_nxt;
  logic [ldsw_pkg::BYTE_W-1:0]        shift_byte_r, shift_byte_nxt;
  logic [ldsw_pkg::BIT_CNT_W-1:0]     bit_count_r, bit_count_nxt;
  logic [ldsw_pkg::IDX_W-1:0]         byte_index_r, byte_index_nxt;
  logic [ldsw_pkg::PACKET_W-1:0]      packet_r, packet_nxt;
  logic [ldsw_pkg::LEVEL_W-1:0]       level_store_r, level_store_nxt;
  logic                               clearing_r, clearing_nxt;
  logic                               clk_q_r, clk_q_nxt;
  logic                               dat_q_r, dat_q_nxt;
  logic                               drv_q_r, drv_q_nxt;
  logic [ldsw_pkg::STORE_DEPTH-1:0][ldsw_pkg::BYTE_W-1:0] digit_store_r;
  logic                               store_we;
  logic                               start;
  logic                               done;
  logic                               rej;
  logic [ldsw_pkg::BYTE_W-1:0]        seg_byte;
  logic [ldsw_pkg::BYTE_W-1:0]        disp_byte;
  logic                               out_valid_r;
  logic                               clock_level_r, data_level_r, data_drive_r;
  logic                               busy_r, done_r, rej_r;
  logic                               step;

  assign req_ready = !out_valid_r || !out_stall;
  assign step      = req_valid && req_ready;

  always_comb begin
    if (clearing_r || (byte_index_r >= ldsw_pkg::IDX_W'(ldsw_pkg::STORE_DEPTH))) begin
      seg_byte = '0;
    end else begin
      seg_byte = digit_store_r[byte_index_r[ldsw_pkg::STORE_IDX_W-1:0]];
    end
    disp_byte = clearing_r ? ldsw_pkg::CMD_DISP_OFF
                           : (ldsw_pkg::CMD_DISP_ON | {5'd0, level_store_r});
  end

  always_comb begin
    phase_nxt       = phase_r;
    shift_byte_nxt  = shift_byte_r;
    bit_count_nxt   = bit_count_r;
    byte_index_nxt  = byte_index_r;
    packet_nxt      = packet_r;
    level_store_nxt = level_store_r;
    clearing_nxt    = clearing_r;
    clk_q_nxt       = clk_q_r;
    dat_q_nxt       = dat_q_r;
    drv_q_nxt       = drv_q_r;
    store_we        = 1'b0;
    start           = 1'b0;
    done            = 1'b0;
    rej             = 1'b0;
    unique case (phase_r)
      P_IDLE: begin
        unique case (req.kind)
          ldsw_pkg::KIND_SHOW: begin
            store_we        = 1'b1;
            level_store_nxt = req.level;
            clearing_nxt    = 1'b0;
            start           = 1'b1;
          end
          ldsw_pkg::KIND_CLEAR: begin
            clearing_nxt = 1'b1;
            start        = 1'b1;
          end
          ldsw_pkg::KIND_BAD: begin
            rej = 1'b1;
          end
          default: begin
          end
        endcase
        if (start) begin
          packet_nxt     = '0;
          byte_index_nxt = '0;
          bit_count_nxt  = '0;
          shift_byte_nxt = ldsw_pkg::CMD_DATA_SET;
          phase_nxt      = P_START;
        end
      end
      P_START: begin
        clk_q_nxt     = 1'b1;
        dat_q_nxt     = 1'b0;
        drv_q_nxt     = 1'b1;
        bit_count_nxt = '0;
        phase_nxt     = P_BIT_LOW;
      end
      P_BIT_LOW: begin
        clk_q_nxt = 1'b0;
        drv_q_nxt = 1'b1;
        dat_q_nxt = shift_byte_r[bit_count_r];
        phase_nxt = P_BIT_HIGH;
      end
      P_BIT_HIGH: begin
        clk_q_nxt = 1'b1;
        if (bit_count_r == ldsw_pkg::BIT_CNT_W'(ldsw_pkg::BITS_PER_BYTE - 1)) begin
          phase_nxt = P_ACK_REL;
        end else begin
          bit_count_nxt = bit_count_r + 1'b1;
          phase_nxt     = P_BIT_LOW;
        end
      end
      P_ACK_REL: begin
        clk_q_nxt = 1'b0;
        dat_q_nxt = 1'b0;
        drv_q_nxt = 1'b0;
        phase_nxt = P_ACK_WAIT;
      end
      P_ACK_WAIT: begin
        if (!req.pin) begin
          clk_q_nxt = 1'b1;
          if ((packet_r == 2'd1) && (byte_index_r < ldsw_pkg::IDX_W'(ldsw_pkg::DIGITS))) begin
            shift_byte_nxt = seg_byte;
            byte_index_nxt = byte_index_r + 1'b1;
            bit_count_nxt  = '0;
            phase_nxt      = P_BIT_LOW;
          end else begin
            phase_nxt = P_STOP_LOW;
          end
        end
      end
      P_STOP_LOW: begin
        clk_q_nxt = 1'b0;
        dat_q_nxt = 1'b0;
        drv_q_nxt = 1'b1;
        phase_nxt = P_STOP_CLK;
      end
      P_STOP_CLK: begin
        clk_q_nxt = 1'b1;
        phase_nxt = P_STOP_DAT;
      end
      default: begin
        // Final tick of a stop: data rises while the clock is high.
        clk_q_nxt = 1'b1;
        dat_q_nxt = 1'b1;
        drv_q_nxt = 1'b1;
        if (packet_r >= 2'd2) begin
          done       = 1'b1;
          packet_nxt = '0;
          phase_nxt  = P_IDLE;
        end else begin
          packet_nxt     = packet_r + 1'b1;
          shift_byte_nxt = (packet_r == 2'd0) ? ldsw_pkg::CMD_ADDRESS : disp_byte;
          byte_index_nxt = '0;
          phase_nxt      = P_START;
        end
      end
    endcase
    if ((phase_r != P_IDLE) && !done && (req.kind != ldsw_pkg::KIND_TICK)) begin
      rej = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && store_we) begin
      digit_store_r <= req.digits;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      clock_level_r <= clk_q_nxt;
      data_level_r  <= drv_q_nxt & dat_q_nxt;
      data_drive_r  <= drv_q_nxt;
      busy_r        <= (phase_nxt != P_IDLE);
      done_r        <= done;
      rej_r         <= rej;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= P_IDLE;
      shift_byte_r  <= '0;
      bit_count_r   <= '0;
      byte_index_r  <= '0;
      packet_r      <= '0;
      level_store_r <= '0;
      clearing_r    <= 1'b0;
      clk_q_r       <= 1'b1;
      dat_q_r       <= 1'b1;
      drv_q_r       <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r       <= phase_nxt;
        shift_byte_r  <= shift_byte_nxt;
        bit_count_r   <= bit_count_nxt;
        byte_index_r  <= byte_index_nxt;
        packet_r      <= packet_nxt;
        level_store_r <= level_store_nxt;
        clearing_r    <= clearing_nxt;
        clk_q_r       <= clk_q_nxt;
        dat_q_r       <= dat_q_nxt;
        drv_q_r       <= drv_q_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_clock_level = clock_level_r;
  assign out_data_level  = data_level_r;
  assign out_data_drive  = data_drive_r;
  assign out_busy_res    = busy_r;
  assign out_frame_done  = done_r;
  assign out_rejected    = rej_r;

endmodule

// File: rtl/led_display_serial_writer.sv
// Top level of the LED display serial writer: front end, request queue and line sequencer.
//
// Each request is one bit-timing tick and yields exactly one result that gives the clock and
// data line levels after that tick. The block takes one request per clock cycle while the
// result side does not stall; a request is held in the queue and its result is then
// registered in the output register. The sequencer advances the line state by one half-step
// for each request. A show with brightness above 7, or any show or clear while a frame is
// running, is refused with the rejected flag; the tick that completes the final stop of a
// frame raises frame_done.
module led_display_serial_writer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ldsw_pkg::MODE_W-1:0]   in_mode,
  input  logic [ldsw_pkg::BYTE_W-1:0]   in_digit0,
  input  logic [ldsw_pkg::BYTE_W-1:0]   in_digit1,
  input  logic [ldsw_pkg::BYTE_W-1:0]   in_digit2,
  input  logic [ldsw_pkg::BYTE_W-1:0]   in_digit3,
  input  logic [ldsw_pkg::BRIGHT_W-1:0] in_brightness,
  input  logic                          in_data_pin_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_clock_level,
  output logic                          out_data_level,
  output logic                          out_data_drive,
  output logic                          out_busy_res,
  output logic                          out_frame_done,
  output logic                          out_rejected
);

  ldsw_pkg::req_t front_req;
  ldsw_pkg::req_t queue_req;
  logic           queue_valid;
  logic           back_ready;

  ldsw_front u_front (
    .mode        (in_mode),
    .digit0      (in_digit0),
    .digit1      (in_digit1),
    .digit2      (in_digit2),
    .digit3      (in_digit3),
    .brightness  (in_brightness),
    .data_pin_in (in_data_pin_in),
    .req         (front_req)
  );

  ldsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_req   (front_req),
    .push_stall (in_stall),
    .pop_valid  (queue_valid),
    .pop_req    (queue_req),
    .pop_ready  (back_ready)
  );

  ldsw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (queue_valid),
    .req             (queue_req),
    .req_ready       (back_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clock_level (out_clock_level),
    .out_data_level  (out_data_level),
    .out_data_drive  (out_data_drive),
    .out_busy_res    (out_busy_res),
    .out_frame_done  (out_frame_done),
    .out_rejected    (out_rejected)
  );

endmodule

// File: rtl/ldsw_checker.sv
// Port-level checks on the LED display serial writer, bound to its top level.
module ldsw_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_clock_level,
  input logic out_data_level,
  input logic out_data_drive,
  input logic out_busy_res,
  input logic out_frame_done,
  input logic out_rejected
);

  // A released data line never shows a driven high level.
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_drive |-> !out_data_level)
    else $error("Data level high while the line is released.");

  // The tick that finishes a frame leaves the block idle and refuses nothing.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_busy_res && !out_rejected)
    else $error("Frame completion reported while still busy or refusing a request.");

  // A frame ends with both lines high and driven.
  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_clock_level && out_data_level && out_data_drive)
    else $error("Frame completion without a stop condition on the lines.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_clock_level)
      && $stable(out_data_level) && $stable(out_data_drive) && $stable(out_busy_res)
      && $stable(out_frame_done) && $stable(out_rejected))
    else $error("Stalled result changed or was withdrawn.");

endmodule

bind led_display_serial_writer ldsw_checker u_ldsw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_clock_level (out_clock_level),
  .out_data_level  (out_data_level),
  .out_data_drive  (out_data_drive),
  .out_busy_res    (out_busy_res),
  .out_frame_done  (out_frame_done),
  .out_rejected    (out_rejected)
);
